### hw/rtl/hid_keyboard_report_builder_assert.svh
// Assertion macros for the HID keyboard report builder.
`ifndef HID_KEYBOARD_REPORT_BUILDER_ASSERT_SVH
`define HID_KEYBOARD_REPORT_BUILDER_ASSERT_SVH
`ifndef ASSERT_OFF
`define HKRB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define HKRB_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define HKRB_ASSERT(lbl, prop, msg)
`define HKRB_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### hw/rtl/hkrb_pkg.sv
// Shared constants and types of the HID keyboard report builder.
package hkrb_pkg;
   localparam int KEY_SLOTS_DEF   = 16;
   localparam int BLOCK_SLOTS_DEF = 4;
   localparam int REPORT_KEYS     = 6;
   localparam int MODIFIER_COUNT  = 8;

   // request function codes
   localparam logic [2:0] FN_PRESS_MOD   = 3'd0;
   localparam logic [2:0] FN_RELEASE_MOD = 3'd1;
   localparam logic [2:0] FN_PRESS_KEY   = 3'd2;
   localparam logic [2:0] FN_RELEASE_KEY = 3'd3;
   localparam logic [2:0] FN_BLOCK       = 3'd4;
   localparam logic [2:0] FN_UNBLOCK     = 3'd5;
   localparam logic [2:0] FN_REPORT      = 3'd6;
   localparam logic [2:0] FN_QUERY       = 3'd7;

   // error codes
   localparam logic [1:0] ERR_OK         = 2'd0;
   localparam logic [1:0] ERR_KEY_FULL   = 2'd1;
   localparam logic [1:0] ERR_BLOCK_FULL = 2'd2;
   localparam logic [1:0] ERR_BAD_HANDLE = 2'd3;

   // one held key
   typedef struct packed {
      logic [7:0]  code;
      logic [7:0]  count;
      logic        reported;
      logic [63:0] act;
   } key_entry_type;

   // table write request
   typedef struct packed {
      logic          en;
      key_entry_type data;
   } key_wr_type;
endpackage

### hw/rtl/hkrb_key_mem.sv
// Key table memory: one write port, one registered read port.
module hkrb_key_mem #(
   parameter int DEPTH = hkrb_pkg::KEY_SLOTS_DEF
) (
   input  logic                        clock,
   input  hkrb_pkg::key_wr_type        wr,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output hkrb_pkg::key_entry_type     rd_data
);
   hkrb_pkg::key_entry_type mem [DEPTH];
   hkrb_pkg::key_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/hid_keyboard_report_builder.sv
// Top level of the HID boot keyboard report builder (6-key rollover).
//
//   channel  ports   handshake
//   request  req_*   start & !busy
//   result   rsp_*   rsp_valid, one cycle, no back-pressure
//
// Modifier, block, unblock and query beats: busy in the done state only, strobe right after it.
// Key and report beats walk the table through its one read port: a read and a check
// state per entry visited, then the end check (or a hit) and the done state; each
// removal adds a read and a move state per entry moved down, plus a final read.
// Synchronous reset clears counts, used count and blocks; table contents stay.
// No back-pressure on results; a new beat may start in the strobe cycle.
module hid_keyboard_report_builder #(
   parameter int KEY_SLOTS   = hkrb_pkg::KEY_SLOTS_DEF,
   parameter int BLOCK_SLOTS = hkrb_pkg::BLOCK_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [2:0]  req_modifier_index,
   input  logic [7:0]  req_keycode,
   input  logic [63:0] req_timestamp,
   input  logic [1:0]  req_block_handle,
   output logic        rsp_valid,
   output logic        rsp_has_report,
   output logic [7:0]  rsp_modifier_bits,
   output logic [7:0]  rsp_key_slot0,
   output logic [7:0]  rsp_key_slot1,
   output logic [7:0]  rsp_key_slot2,
   output logic [7:0]  rsp_key_slot3,
   output logic [7:0]  rsp_key_slot4,
   output logic [7:0]  rsp_key_slot5,
   output logic [1:0]  rsp_handle_out,
   output logic [1:0]  rsp_error_code
);
`include "hid_keyboard_report_builder_assert.svh"

   localparam int IDXW = $clog2(KEY_SLOTS);
   localparam int CNTW = $clog2(KEY_SLOTS + 1);
   localparam int ORDW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
   localparam int NW   = $clog2(hkrb_pkg::REPORT_KEYS);

   typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_MRD, S_MCHK, S_DONE} state_type;

   state_type state_ff;
   logic [2:0]  op_ff;
   logic [7:0]  code_ff;
   logic [63:0] ts_ff;
   logic [CNTW-1:0] idx_ff, mv_ff, used_ff;
   logic [NW-1:0] n_ff;
   logic        hit_ff;
   logic        blocked_ff;
   logic [63:0] limit_ff;
   logic        last_empty_ff;
   logic [7:0]  mod_cnt_ff [hkrb_pkg::MODIFIER_COUNT];
   logic [63:0] blk_time_ff [BLOCK_SLOTS];
   logic [BLOCK_SLOTS-1:0] blk_valid_ff;
   logic [ORDW-1:0] blk_order_ff [BLOCK_SLOTS];
   logic [7:0]  keys_ff [hkrb_pkg::REPORT_KEYS];
   logic [1:0]  handle_ff, err_ff;

   logic        rsp_valid_ff, rsp_has_ff;
   logic [7:0]  rsp_mods_ff;
   logic [7:0]  rsp_keys_ff [hkrb_pkg::REPORT_KEYS];
   logic [1:0]  rsp_handle_ff, rsp_err_ff;

   hkrb_pkg::key_wr_type    wr;
   logic [IDXW-1:0]         wr_addr, rd_addr;
   hkrb_pkg::key_entry_type rd_data;

   hkrb_key_mem #(.DEPTH(KEY_SLOTS)) u_mem (
      .clock   (clock),
      .wr      (wr),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // modifier byte from counts
   logic [7:0] mod_bits;
   always_comb begin
      for (int i = 0; i < hkrb_pkg::MODIFIER_COUNT; i++) begin
         mod_bits[i] = (mod_cnt_ff[i] != 8'd0);
      end
   end

   // entry under test
   logic code_match, purge, visible;
   logic [7:0] cnt_dec;
   assign code_match = (rd_data.code == code_ff);
   assign purge      = (rd_data.count == 8'd0) && rd_data.reported;
   assign visible    = !blocked_ff || (rd_data.act <= limit_ff);
   assign cnt_dec    = (rd_data.count != 8'd0) ? rd_data.count - 8'd1 : 8'd0;

   // read address: table walk or compaction source
   assign rd_addr = (state_ff == S_MRD) ? IDXW'(mv_ff + CNTW'(1)) : idx_ff[IDXW-1:0];

   // table write port
   always_comb begin
      wr      = '0;
      wr_addr = idx_ff[IDXW-1:0];
      unique case (state_ff)
         S_RD: begin
            if (idx_ff == used_ff && op_ff == hkrb_pkg::FN_PRESS_KEY
                && used_ff != CNTW'(KEY_SLOTS)) begin
               wr.en            = 1'b1;
               wr.data.code     = code_ff;
               wr.data.count    = 8'd1;
               wr.data.reported = 1'b0;
               wr.data.act      = ts_ff;
               wr_addr          = used_ff[IDXW-1:0];
            end
         end
         S_CHK: begin
            wr.data = rd_data;
            case (op_ff)
               hkrb_pkg::FN_PRESS_KEY: begin
                  wr.en = code_match;
                  if (rd_data.count != 8'hFF) wr.data.count = rd_data.count + 8'd1;
               end
               hkrb_pkg::FN_RELEASE_KEY: begin
                  wr.en         = code_match && !(cnt_dec == 8'd0 && rd_data.reported);
                  wr.data.count = cnt_dec;
               end
               default: begin
                  wr.en            = !purge && visible;
                  wr.data.reported = 1'b1;
               end
            endcase
         end
         S_MCHK: begin
            wr.en   = 1'b1;
            wr.data = rd_data;
            wr_addr = mv_ff[IDXW-1:0];
         end
         default: ;
      endcase
   end

   // block list lookups for the accept cycle
   logic [BLOCK_SLOTS-1:0] free_slot;
   logic                   any_free;
   logic [ORDW-1:0]        active_n;
   logic                   hnd_ok;
   logic [ORDW-1:0]        hnd_rank;
   logic                   blocked_now;
   logic [63:0]            limit_now;
   always_comb begin
      free_slot   = '0;
      any_free    = 1'b0;
      active_n    = '0;
      hnd_ok      = 1'b0;
      hnd_rank    = '0;
      blocked_now = 1'b0;
      limit_now   = '0;
      for (int s = 0; s < BLOCK_SLOTS; s++) begin
         if (!blk_valid_ff[s] && !any_free) begin
            free_slot[s] = 1'b1;
            any_free     = 1'b1;
         end
         if (blk_valid_ff[s]) active_n = active_n + ORDW'(1);
         if (s < 4 && 2'(s) == req_block_handle && blk_valid_ff[s]) begin
            hnd_ok   = 1'b1;
            hnd_rank = blk_order_ff[s];
         end
         if (blk_valid_ff[s] && blk_order_ff[s] == '0) begin
            blocked_now = 1'b1;
            limit_now   = blk_time_ff[s];
         end
      end
   end

   logic le_next;
   assign le_next = (op_ff == hkrb_pkg::FN_REPORT) ? !(|mod_bits || hit_ff) : last_empty_ff;

   // sequencer
   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         blk_valid_ff  <= '0;
         last_empty_ff <= 1'b1;
         for (int i = 0; i < hkrb_pkg::MODIFIER_COUNT; i++) mod_cnt_ff[i] <= 8'd0;
         for (int s = 0; s < BLOCK_SLOTS; s++) blk_order_ff[s] <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff      <= req_func;
                  code_ff    <= req_keycode;
                  ts_ff      <= req_timestamp;
                  idx_ff     <= '0;
                  n_ff       <= '0;
                  hit_ff     <= 1'b0;
                  handle_ff  <= 2'd0;
                  err_ff     <= hkrb_pkg::ERR_OK;
                  blocked_ff <= blocked_now;
                  limit_ff   <= limit_now;
                  for (int k = 0; k < hkrb_pkg::REPORT_KEYS; k++) keys_ff[k] <= 8'd0;
                  state_ff   <= S_DONE;
                  case (req_func)
                     hkrb_pkg::FN_PRESS_MOD: begin
                        if (mod_cnt_ff[req_modifier_index] != 8'hFF)
                           mod_cnt_ff[req_modifier_index] <=
                              mod_cnt_ff[req_modifier_index] + 8'd1;
                     end
                     hkrb_pkg::FN_RELEASE_MOD: begin
                        if (mod_cnt_ff[req_modifier_index] != 8'd0)
                           mod_cnt_ff[req_modifier_index] <=
                              mod_cnt_ff[req_modifier_index] - 8'd1;
                     end
                     hkrb_pkg::FN_PRESS_KEY, hkrb_pkg::FN_RELEASE_KEY,
                     hkrb_pkg::FN_REPORT: begin
                        state_ff <= S_RD;
                     end
                     hkrb_pkg::FN_BLOCK: begin
                        if (!any_free) err_ff <= hkrb_pkg::ERR_BLOCK_FULL;
                        for (int s = 0; s < BLOCK_SLOTS; s++) begin
                           if (free_slot[s]) begin
                              blk_valid_ff[s] <= 1'b1;
                              blk_time_ff[s]  <= req_timestamp;
                              blk_order_ff[s] <= active_n;
                              handle_ff       <= 2'(s);
                           end
                        end
                     end
                     hkrb_pkg::FN_UNBLOCK: begin
                        if (!hnd_ok) err_ff <= hkrb_pkg::ERR_BAD_HANDLE;
                        for (int s = 0; s < BLOCK_SLOTS; s++) begin
                           if (hnd_ok) begin
                              if (s < 4 && 2'(s) == req_block_handle) begin
                                 blk_valid_ff[s] <= 1'b0;
                                 blk_order_ff[s] <= '0;
                              end else if (blk_valid_ff[s] && blk_order_ff[s] > hnd_rank) begin
                                 blk_order_ff[s] <= blk_order_ff[s] - ORDW'(1);
                              end
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
            // end of table, or fetch the entry
            S_RD: begin
               if (idx_ff == used_ff) begin
                  if (op_ff == hkrb_pkg::FN_PRESS_KEY) begin
                     if (used_ff == CNTW'(KEY_SLOTS)) err_ff <= hkrb_pkg::ERR_KEY_FULL;
                     else used_ff <= used_ff + CNTW'(1);
                  end
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               state_ff <= S_RD;
               idx_ff   <= idx_ff + CNTW'(1);
               case (op_ff)
                  hkrb_pkg::FN_PRESS_KEY: begin
                     if (code_match) state_ff <= S_DONE;
                  end
                  hkrb_pkg::FN_RELEASE_KEY: begin
                     if (code_match) begin
                        if (cnt_dec == 8'd0 && rd_data.reported) begin
                           mv_ff    <= idx_ff;
                           state_ff <= S_MRD;
                        end else begin
                           state_ff <= S_DONE;
                        end
                     end
                  end
                  default: begin
                     if (purge) begin
                        mv_ff    <= idx_ff;
                        idx_ff   <= idx_ff;
                        state_ff <= S_MRD;
                     end else if (visible) begin
                        keys_ff[n_ff] <= rd_data.code;
                        hit_ff        <= 1'b1;
                        n_ff          <= n_ff + NW'(1);
                        if (n_ff == NW'(hkrb_pkg::REPORT_KEYS - 1)) state_ff <= S_DONE;
                     end
                  end
               endcase
            end
            // compaction: move entries down over the removed one
            S_MRD: begin
               if (mv_ff + CNTW'(1) < used_ff) begin
                  state_ff <= S_MCHK;
               end else begin
                  used_ff  <= used_ff - CNTW'(1);
                  state_ff <= (op_ff == hkrb_pkg::FN_REPORT) ? S_RD : S_DONE;
               end
            end
            S_MCHK: begin
               mv_ff    <= mv_ff + CNTW'(1);
               state_ff <= S_MRD;
            end
            S_DONE: begin
               last_empty_ff <= le_next;
               rsp_valid_ff  <= 1'b1;
               rsp_has_ff    <= !le_next || |mod_bits || (used_ff != '0);
               rsp_mods_ff   <= (op_ff == hkrb_pkg::FN_REPORT) ? mod_bits : 8'd0;
               for (int k = 0; k < hkrb_pkg::REPORT_KEYS; k++) rsp_keys_ff[k] <= keys_ff[k];
               rsp_handle_ff <= handle_ff;
               rsp_err_ff    <= err_ff;
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_has_report    = rsp_has_ff;
   assign rsp_modifier_bits = rsp_mods_ff;
   assign rsp_key_slot0     = rsp_keys_ff[0];
   assign rsp_key_slot1     = rsp_keys_ff[1];
   assign rsp_key_slot2     = rsp_keys_ff[2];
   assign rsp_key_slot3     = rsp_keys_ff[3];
   assign rsp_key_slot4     = rsp_keys_ff[4];
   assign rsp_key_slot5     = rsp_keys_ff[5];
   assign rsp_handle_out    = rsp_handle_ff;
   assign rsp_error_code    = rsp_err_ff;

   `HKRB_ASSERT_NEVER(a_used_range, used_ff > CNTW'(KEY_SLOTS), "key table overfilled")
   `HKRB_ASSERT(a_strobe_from_done, rsp_valid_ff |-> $past(state_ff == S_DONE), "stray strobe")
   `HKRB_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted beat not taken")
   `HKRB_ASSERT_NEVER(a_move_range, state_ff == S_MCHK && mv_ff + CNTW'(1) >= used_ff,
                      "compaction past table end")
endmodule

### sim/tb_hid_keyboard_report_builder.sv
// Self-checking testbench for the HID boot keyboard report builder.
module tb_hid_keyboard_report_builder;

   localparam int KEYS   = hkrb_pkg::KEY_SLOTS_DEF;
   localparam int BLOCKS = hkrb_pkg::BLOCK_SLOTS_DEF;
   localparam longint LIMIT_CYCLES = 2000000;

   typedef struct packed {
      logic [2:0]  func;
      logic [2:0]  modifier_index;
      logic [7:0]  keycode;
      logic [63:0] timestamp;
      logic [1:0]  block_handle;
   } event_type;

   typedef struct packed {
      logic        has_report;
      logic [7:0]  modifier_bits;
      logic [47:0] keys;
      logic [1:0]  handle_out;
      logic [1:0]  error_code;
   } report_type;

   logic clock, reset, start, busy;
   logic [2:0] req_func, req_modifier_index;
   logic [7:0] req_keycode;
   logic [63:0] req_timestamp;
   logic [1:0] req_block_handle;
   logic rsp_valid, rsp_has_report;
   logic [7:0] rsp_modifier_bits, rsp_key_slot0, rsp_key_slot1, rsp_key_slot2;
   logic [7:0] rsp_key_slot3, rsp_key_slot4, rsp_key_slot5;
   logic [1:0] rsp_handle_out, rsp_error_code;

   hid_keyboard_report_builder uut (.*);

   // predictor state
   logic [7:0]  mod_cnt [8];
   logic [7:0]  kt_code [KEYS];
   logic [7:0]  kt_cnt  [KEYS];
   logic        kt_rep  [KEYS];
   logic [63:0] kt_act  [KEYS];
   int          kt_used;
   logic [63:0] blk_time [BLOCKS];
   logic        blk_valid [BLOCKS];
   int          blk_rank [BLOCKS];
   logic        last_empty;

   event_type  pending_events[$];
   report_type expected_reports[$];
   logic    driver_done, hold_for_drain;
   int      gap_left;
   int      fail_count = 0;
   longint  cycle_count = 0;

   function automatic void drop_key(int idx);
      for (int j = idx; j + 1 < kt_used; j++) begin
         kt_code[j] = kt_code[j+1]; kt_cnt[j] = kt_cnt[j+1];
         kt_rep[j] = kt_rep[j+1];   kt_act[j] = kt_act[j+1];
      end
      if (kt_used > 0) kt_used--;
   endfunction

   function automatic int find_key(logic [7:0] code);
      for (int i = 0; i < kt_used; i++)
         if (kt_code[i] == code) return i;
      return -1;
   endfunction

   function automatic report_type build_report(event_type ev);
      report_type r;
      int k, n, i, rank;
      logic blocked, empty;
      logic [63:0] lim;
      r = '0;
      case (ev.func)
         hkrb_pkg::FN_PRESS_MOD: if (mod_cnt[ev.modifier_index] != 8'hff)
            mod_cnt[ev.modifier_index]++;
         hkrb_pkg::FN_RELEASE_MOD: if (mod_cnt[ev.modifier_index] != 0)
            mod_cnt[ev.modifier_index]--;
         hkrb_pkg::FN_PRESS_KEY: begin
            k = find_key(ev.keycode);
            if (k >= 0) begin
               if (kt_cnt[k] != 8'hff) kt_cnt[k]++;
            end else if (kt_used >= KEYS) begin
               r.error_code = hkrb_pkg::ERR_KEY_FULL;
            end else begin
               kt_code[kt_used] = ev.keycode; kt_cnt[kt_used] = 1;
               kt_rep[kt_used] = 0; kt_act[kt_used] = ev.timestamp;
               kt_used++;
            end
         end
         hkrb_pkg::FN_RELEASE_KEY: begin
            k = find_key(ev.keycode);
            if (k >= 0) begin
               if (kt_cnt[k] != 0) kt_cnt[k]--;
               if (kt_cnt[k] == 0 && kt_rep[k]) drop_key(k);
            end
         end
         hkrb_pkg::FN_BLOCK: begin
            n = 0;
            for (int s = 0; s < BLOCKS; s++) if (blk_valid[s]) n++;
            r.error_code = hkrb_pkg::ERR_BLOCK_FULL;
            for (int s = 0; s < BLOCKS; s++)
               if (!blk_valid[s] && r.error_code != hkrb_pkg::ERR_OK) begin
                  blk_valid[s] = 1; blk_time[s] = ev.timestamp; blk_rank[s] = n;
                  r.handle_out = s[1:0]; r.error_code = hkrb_pkg::ERR_OK;
               end
         end
         hkrb_pkg::FN_UNBLOCK: begin
            if (!blk_valid[ev.block_handle]) begin
               r.error_code = hkrb_pkg::ERR_BAD_HANDLE;
            end else begin
               rank = blk_rank[ev.block_handle];
               blk_valid[ev.block_handle] = 0; blk_rank[ev.block_handle] = 0;
               for (int s = 0; s < BLOCKS; s++)
                  if (blk_valid[s] && blk_rank[s] > rank) blk_rank[s]--;
            end
         end
         hkrb_pkg::FN_REPORT: begin
            empty = 1; blocked = 0; lim = '0; n = 0;
            for (int m = 0; m < 8; m++)
               if (mod_cnt[m] != 0) begin r.modifier_bits[m] = 1; empty = 0; end
            for (int s = 0; s < BLOCKS; s++)
               if (blk_valid[s] && blk_rank[s] == 0) begin blocked = 1; lim = blk_time[s]; end
            i = 0;
            while (i < kt_used && n < hkrb_pkg::REPORT_KEYS) begin
               if (kt_cnt[i] == 0 && kt_rep[i]) begin
                  drop_key(i);
               end else begin
                  if (!blocked || kt_act[i] <= lim) begin
                     r.keys[n*8 +: 8] = kt_code[i]; kt_rep[i] = 1; empty = 0; n++;
                  end
                  i++;
               end
            end
            last_empty = empty;
         end
         default: ;
      endcase
      r.has_report = !last_empty || kt_used > 0;
      for (int m = 0; m < 8; m++) if (mod_cnt[m] != 0) r.has_report = 1;
      return r;
   endfunction

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // driver: issue beats with random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 0; gap_left <= 0; driver_done <= 0;
         req_func <= hkrb_pkg::FN_QUERY; req_modifier_index <= 0; req_keycode <= 0;
         req_timestamp <= 0; req_block_handle <= 0;
         for (int m = 0; m < 8; m++) mod_cnt[m] = 0;
         for (int s = 0; s < BLOCKS; s++) begin blk_valid[s] = 0; blk_rank[s] = 0; end
         kt_used = 0; last_empty = 1;
      end else if (start && !busy) begin
         // beat accepted this edge
         expected_reports = {expected_reports, build_report({req_func, req_modifier_index,
            req_keycode, req_timestamp, req_block_handle})};
         start <= 0;
         gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                  : $urandom_range(0, 2);
      end else if (!start) begin
         if (gap_left > 0) gap_left <= gap_left - 1;
         else if (hold_for_drain && expected_reports.size() != 0) ;
         else if (pending_events.size() != 0) begin
            event_type ev;
            ev = pending_events.pop_front();
            req_func <= ev.func; req_modifier_index <= ev.modifier_index;
            req_keycode <= ev.keycode; req_timestamp <= ev.timestamp;
            req_block_handle <= ev.block_handle;
            start <= 1;
         end else driver_done <= 1;
      end
   end

   // monitor: compare every strobe against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         report_type got, want;
         got = {rsp_has_report, rsp_modifier_bits, rsp_key_slot5, rsp_key_slot4,
                rsp_key_slot3, rsp_key_slot2, rsp_key_slot1, rsp_key_slot0,
                rsp_handle_out, rsp_error_code};
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            fail_count++;
         end else begin
            want = expected_reports.pop_front();
            if (got.has_report !== want.has_report) begin
               $display("%0t: has_report exp %h got %h", $time, want.has_report, got.has_report);
               fail_count++;
            end
            if (got.modifier_bits !== want.modifier_bits) begin
               $display("%0t: modifier_bits exp %h got %h", $time,
                        want.modifier_bits, got.modifier_bits);
               fail_count++;
            end
            for (int s = 0; s < hkrb_pkg::REPORT_KEYS; s++)
               if (got.keys[s*8 +: 8] !== want.keys[s*8 +: 8]) begin
                  $display("%0t: key_slot%0d exp %h got %h", $time, s,
                           want.keys[s*8 +: 8], got.keys[s*8 +: 8]);
                  fail_count++;
               end
            if (got.handle_out !== want.handle_out) begin
               $display("%0t: handle_out exp %h got %h", $time, want.handle_out, got.handle_out);
               fail_count++;
            end
            if (got.error_code !== want.error_code) begin
               $display("%0t: error_code exp %h got %h", $time, want.error_code, got.error_code);
               fail_count++;
            end
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic add_event(logic [2:0] f, logic [2:0] m, logic [7:0] k,
                            logic [63:0] t, logic [1:0] h);
      event_type ev;
      ev.func = f; ev.modifier_index = m; ev.keycode = k;
      ev.timestamp = t; ev.block_handle = h;
      pending_events = {pending_events, ev};
   endtask

   // random stimulus: mostly a small keycode pool with a moving clock
   task automatic add_random(int count, ref logic [63:0] now);
      int r;
      logic [7:0] k;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         now += $urandom_range(0, 3);
         k = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
         if (r < 8)
            add_event(hkrb_pkg::FN_PRESS_MOD, 3'($urandom), 8'($urandom), 64'($urandom),
                      2'($urandom));
         else if (r < 16)
            add_event(hkrb_pkg::FN_RELEASE_MOD, 3'($urandom), 8'($urandom), 64'($urandom),
                      2'($urandom));
         else if (r < 40)
            add_event(hkrb_pkg::FN_PRESS_KEY, 3'($urandom), k, now, 2'($urandom));
         else if (r < 60)
            add_event(hkrb_pkg::FN_RELEASE_KEY, 3'($urandom), k, 64'($urandom), 2'($urandom));
         else if (r < 66)
            add_event(hkrb_pkg::FN_BLOCK, 3'($urandom), 8'($urandom),
                      now - $urandom_range(0, 4), 2'($urandom));
         else if (r < 74)
            add_event(hkrb_pkg::FN_UNBLOCK, 3'($urandom), 8'($urandom), 64'($urandom),
                      2'($urandom));
         else if (r < 96)
            add_event(hkrb_pkg::FN_REPORT, 3'($urandom), 8'($urandom), 64'($urandom),
                      2'($urandom));
         else
            add_event(hkrb_pkg::FN_QUERY, 3'($urandom), 8'($urandom), 64'($urandom),
                      2'($urandom));
      end
   endtask

   initial begin
      logic [63:0] now;
      int wait_cycles;
      reset = 1; hold_for_drain = 0;

      // directed: extremes, every function, full tables, bad handle
      add_event(hkrb_pkg::FN_QUERY, 0, 0, 0, 0);
      add_event(hkrb_pkg::FN_UNBLOCK, 7, 8'hff, '1, 3);
      add_event(hkrb_pkg::FN_RELEASE_MOD, 7, 0, 0, 0);
      add_event(hkrb_pkg::FN_PRESS_MOD, 7, 8'hff, '1, 3);
      add_event(hkrb_pkg::FN_RELEASE_KEY, 0, 8'h55, 0, 0);
      add_event(hkrb_pkg::FN_PRESS_KEY, 0, 8'hff, '1, 0);
      add_event(hkrb_pkg::FN_PRESS_KEY, 0, 8'h00, 64'd0, 0);
      add_event(hkrb_pkg::FN_BLOCK, 0, 0, 64'd5, 0);
      add_event(hkrb_pkg::FN_REPORT, 0, 0, 0, 0);
      add_event(hkrb_pkg::FN_RELEASE_KEY, 0, 8'h00, 0, 0);
      add_event(hkrb_pkg::FN_UNBLOCK, 0, 0, 0, 0);
      add_event(hkrb_pkg::FN_REPORT, 0, 0, 0, 0);
      for (int b = 0; b < 5; b++) add_event(hkrb_pkg::FN_BLOCK, 0, 0, 64'(100 - b), 0);
      add_event(hkrb_pkg::FN_UNBLOCK, 0, 0, 0, 1);
      add_event(hkrb_pkg::FN_REPORT, 0, 0, 0, 0);
      for (int b = 0; b < 4; b++) add_event(hkrb_pkg::FN_UNBLOCK, 0, 0, 0, 2'(b));
      for (int k = 1; k <= 17; k++) add_event(hkrb_pkg::FN_PRESS_KEY, 0, 8'(k), 64'(k), 0);
      add_event(hkrb_pkg::FN_REPORT, 0, 0, 0, 0);
      for (int k = 1; k <= 17; k++) add_event(hkrb_pkg::FN_RELEASE_KEY, 0, 8'(k), 0, 0);
      add_event(hkrb_pkg::FN_REPORT, 0, 0, 0, 0);
      add_event(hkrb_pkg::FN_REPORT, 0, 0, 0, 0);
      add_event(hkrb_pkg::FN_REPORT, 0, 0, 0, 0);
      add_event(hkrb_pkg::FN_RELEASE_KEY, 0, 8'hff, 0, 0);
      add_event(hkrb_pkg::FN_RELEASE_KEY, 0, 8'hff, 0, 0);
      add_event(hkrb_pkg::FN_RELEASE_MOD, 7, 0, 0, 0);
      add_event(hkrb_pkg::FN_REPORT, 0, 0, 0, 0);
      // saturate a modifier and a key count
      for (int n = 0; n < 257; n++) add_event(hkrb_pkg::FN_PRESS_MOD, 3, 0, 0, 0);
      for (int n = 0; n < 257; n++) add_event(hkrb_pkg::FN_PRESS_KEY, 0, 8'h04, 0, 0);
      add_event(hkrb_pkg::FN_REPORT, 0, 0, 0, 0);
      for (int n = 0; n < 257; n++) add_event(hkrb_pkg::FN_RELEASE_MOD, 3, 0, 0, 0);
      for (int n = 0; n < 257; n++) add_event(hkrb_pkg::FN_RELEASE_KEY, 0, 8'h04, 0, 0);
      add_event(hkrb_pkg::FN_REPORT, 0, 0, 0, 0);

      now = 64'hffff_ffff_0000_0000 * $urandom_range(0, 1);
      add_random(280, now);

      repeat (10) @(posedge clock);
      reset <= 0;

      // pause the sender until everything drains, then resume
      wait (pending_events.size() == 0);
      hold_for_drain = 1;
      add_random(275, now);
      wait (expected_reports.size() == 0);
      hold_for_drain = 0;

      wait (driver_done && !start);
      wait (expected_reports.size() == 0);
      wait_cycles = 0;
      while (wait_cycles < 200) begin @(posedge clock); wait_cycles++; end
      if (fail_count == 0 && expected_reports.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
